>>> sv/ssort_pkg.sv
// ssort_pkg: shared types and codes for the stable counting sort block
// no dependencies

package ssort_pkg;

  localparam int KEY_PORT_W = 16;
  localparam int PAY_W      = 64;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_SORT  = 2'd1;
  localparam logic [1:0] CMD_FETCH = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUSH,
    ST_SUM,
    ST_SUM_LAST,
    ST_PLACE,
    ST_CLEAR,
    ST_FETCH
  } state_t;

endpackage

>>> sv/ssort_ram.sv
// ssort_ram: generic simple dual port ram, one write and one registered read
// no dependencies

module ssort_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/stable_counting_sort.sv
// stable_counting_sort: top level, command decode, sequencer and datapath
// depends on ssort_pkg and ssort_ram

// Commands are taken when start is high and busy is low. A push reads the
// count table in ST_IDLE, then increments the count and writes the store in
// ST_PUSH. A fetch result appears in ST_FETCH for one cycle with strobe high
// and must be taken then, as the receiver cannot stall. A sort makes one pass
// over the count table to form the running sums, one pass over the store to
// place the pairs (one per cycle, limited by the count table's single read
// and write port), and one pass over the count table to clear it again.
// After reset the block is busy while it clears the count table.

module stable_counting_sort
  import ssort_pkg::*;
#(
  parameter int MAX_ITEMS = 1024,
  parameter int KEY_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command,
  input  logic [KEY_PORT_W-1:0] sort_key,
  input  logic [PAY_W-1:0]      payload,
  output logic                  strobe,
  output logic [KEY_PORT_W-1:0] out_key,
  output logic [PAY_W-1:0]      out_payload,
  output logic                  valid_res,
  output logic                  is_last,
  output logic                  overflow
);

  localparam int KW = KEY_BITS;
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int DW = KW + PAY_W;
  localparam int TABLE_DEPTH = 1 << KW;

  state_t state, state_next;

  logic [CW-1:0]    item_count;
  logic [KW-1:0]    largest;
  logic [AW-1:0]    rp;
  logic             ready;
  logic             ovf;
  logic [KW-1:0]    idx;
  logic             pv;
  logic [KW-1:0]    pidx;
  logic [CW-1:0]    acc;
  logic [CW-1:0]    rem;
  logic             va;
  logic             vc;
  logic [KW-1:0]    ckey;
  logic [PAY_W-1:0] cpay;
  logic             fw_v;
  logic [KW-1:0]    fw_key;
  logic [CW-1:0]    fw_val;
  logic [KW-1:0]    pkey;
  logic [PAY_W-1:0] ppay;
  logic             fvalid;
  logic             flast;

  logic             accept;
  logic [KW-1:0]    key_in;
  logic             full;
  logic             fetch_ok;
  logic             fetch_last;
  logic [CW-1:0]    sum;
  logic [CW-1:0]    cval;
  logic [CW-1:0]    cm1;
  logic             place_done;

  logic             cnt_we;
  logic [KW-1:0]    cnt_waddr;
  logic [CW-1:0]    cnt_wdata;
  logic [KW-1:0]    cnt_raddr;
  logic [CW-1:0]    cnt_rdata;
  logic             st_we;
  logic [AW-1:0]    st_raddr;
  logic [DW-1:0]    st_rdata;
  logic             so_we;
  logic [AW-1:0]    so_raddr;
  logic [DW-1:0]    so_rdata;
  logic [KW-1:0]    st_key;

  assign accept     = start && !busy;
  assign key_in     = KW'(sort_key);
  assign full       = (item_count == CW'(MAX_ITEMS));
  assign fetch_ok   = ready && (CW'(rp) < item_count);
  assign fetch_last = (CW'(rp) + CW'(1) == item_count);
  assign sum        = acc + cnt_rdata;
  assign cval       = (fw_v && fw_key == ckey) ? fw_val : cnt_rdata;
  assign cm1        = cval - CW'(1);
  assign st_key     = st_rdata[DW-1:PAY_W];
  assign place_done = (rem == '0) && !va && !vc;

  ssort_ram #(.WIDTH(CW), .DEPTH(TABLE_DEPTH)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  ssort_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (AW'(item_count)),
    .wdata ({pkey, ppay}),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  ssort_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_sorted (
    .clk   (clk),
    .we    (so_we),
    .waddr (AW'(cm1)),
    .wdata ({ckey, cpay}),
    .raddr (so_raddr),
    .rdata (so_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (idx == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_PUSH:  if (!ready && !full) state_next = ST_PUSH;
            CMD_SORT:  if (!ready && item_count != '0) state_next = ST_SUM;
            CMD_FETCH: state_next = ST_FETCH;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_PUSH:     state_next = ST_IDLE;
      ST_SUM: begin
        if (idx == largest) state_next = ST_SUM_LAST;
      end
      ST_SUM_LAST: state_next = ST_PLACE;
      ST_PLACE: begin
        if (place_done) state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (idx == largest) state_next = ST_IDLE;
      end
      ST_FETCH:    state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory controls and result ports
  always_comb begin
    busy      = (state != ST_IDLE);
    cnt_we    = 1'b0;
    cnt_waddr = idx;
    cnt_wdata = '0;
    cnt_raddr = idx;
    st_we     = 1'b0;
    st_raddr  = AW'(rem - CW'(1));
    so_we     = 1'b0;
    so_raddr  = rp;
    strobe    = 1'b0;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        cnt_we = 1'b1;
      end
      ST_IDLE: begin
        cnt_raddr = key_in;
      end
      ST_PUSH: begin
        cnt_we    = 1'b1;
        cnt_waddr = pkey;
        cnt_wdata = cnt_rdata + CW'(1);
        st_we     = 1'b1;
      end
      ST_SUM, ST_SUM_LAST: begin
        cnt_we    = (state == ST_SUM_LAST) || pv;
        cnt_waddr = pidx;
        cnt_wdata = sum;
      end
      ST_PLACE: begin
        cnt_raddr = st_key;
        cnt_we    = vc;
        cnt_waddr = ckey;
        cnt_wdata = cm1;
        so_we     = vc;
      end
      ST_FETCH: begin
        strobe = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
    valid_res   = fvalid;
    is_last     = fvalid && flast;
    overflow    = ovf;
    out_key     = fvalid ? KEY_PORT_W'(so_rdata[DW-1:PAY_W]) : '0;
    out_payload = fvalid ? so_rdata[PAY_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      item_count <= '0;
      largest    <= '0;
      rp         <= '0;
      ready      <= 1'b0;
      ovf        <= 1'b0;
      idx        <= '0;
      pv         <= 1'b0;
      acc        <= '0;
      rem        <= '0;
      va         <= 1'b0;
      vc         <= 1'b0;
      fw_v       <= 1'b0;
      fvalid     <= 1'b0;
      flast      <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_INIT: begin
          idx <= idx + KW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (command)
              CMD_PUSH: begin
                if (!ready && full) ovf <= 1'b1;
              end
              CMD_SORT: begin
                idx <= '0;
                pv  <= 1'b0;
                acc <= '0;
              end
              CMD_FETCH: begin
                fvalid <= fetch_ok;
                flast  <= fetch_last;
                if (fetch_ok) begin
                  if (fetch_last) begin
                    item_count <= '0;
                    largest    <= '0;
                    rp         <= '0;
                    ready      <= 1'b0;
                  end else begin
                    rp <= rp + AW'(1);
                  end
                end
              end
              default: begin
                fvalid <= 1'b0;
              end
            endcase
          end
        end
        ST_PUSH: begin
          item_count <= item_count + CW'(1);
          if (pkey > largest) largest <= pkey;
        end
        ST_SUM: begin
          if (pv) acc <= sum;
          pv   <= 1'b1;
          idx  <= idx + KW'(1);
        end
        ST_SUM_LAST: begin
          rem  <= item_count;
          va   <= 1'b0;
          vc   <= 1'b0;
          fw_v <= 1'b0;
        end
        ST_PLACE: begin
          if (rem != '0) rem <= rem - CW'(1);
          va   <= (rem != '0);
          vc   <= va;
          fw_v <= vc;
          if (place_done) idx <= '0;
        end
        ST_CLEAR: begin
          idx <= idx + KW'(1);
          if (idx == largest) begin
            ready <= 1'b1;
            rp    <= '0;
          end
        end
        ST_FETCH: begin
        end
        default: begin
        end
      endcase
    end
  end

  // payload, key, index and forwarding registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      pkey <= key_in;
      ppay <= payload;
    end
    if (state == ST_SUM) begin
      pidx <= idx;
    end
    if (state == ST_PLACE) begin
      ckey   <= st_key;
      cpay   <= st_rdata[PAY_W-1:0];
      fw_key <= ckey;
      fw_val <= cm1;
    end
  end

endmodule
